>>> src/afr_pkg.sv
// Package for the addressed frame receiver.
// Holds the word types, status and action codes, and sizing constants.
// Used by every module in src; depends on nothing.
`timescale 1ns / 1ps

package afr_pkg;

  // Largest capacity the byte counter has to cover.
  localparam int unsigned MAX_CAPACITY = 1024;
  localparam int unsigned CAP_BITS     = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned CNT_W        = (CAP_BITS > 11) ? CAP_BITS : 11;

  // Frame layout constants.
  localparam int unsigned MIN_FRAME_LEN = 10;
  localparam int unsigned LEN_OVERHEAD  = 9;
  localparam int unsigned DATA_START    = 6;
  localparam int unsigned POS_LEAD      = 0;
  localparam int unsigned POS_ADDR_HI   = 1;
  localparam int unsigned POS_ADDR_LO   = 2;
  localparam int unsigned POS_LENGTH    = 5;

  // Line control bytes.
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  // Configuration register widths and reset values.
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [15:0] STATION_RESET  = 16'd0;
  localparam logic [15:0] GAP_RESET      = 16'd10;
  localparam logic [10:0] CAPACITY_RESET = 11'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_ADDRESS = 2'd0,
    CFG_GAP_LIMIT       = 2'd1,
    CFG_RX_CAPACITY     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LEN_MISM = 3'd2,
    ST_BAD_START = 3'd3,
    ST_OTHER_ADDR = 3'd4,
    ST_BAD_SUM  = 3'd5,
    ST_OVERFLOW = 3'd6,
    ST_TIMEOUT  = 3'd7
  } status_e;

  // Input word.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [15:0] timeout_ticks;
  } afr_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] frame_length;
  } afr_out_t;

endpackage

>>> src/afr_in_stage.sv
// Input register of the addressed frame receiver.
// Captures one input word and holds it until the core takes it.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  afr_pkg::afr_in_t in_data_i,
  output logic             item_valid_o,
  output afr_pkg::afr_in_t item_o,
  input  logic             take_i
);

  logic             valid_q, valid_d;
  afr_pkg::afr_in_t word_q, word_d;
  logic             load;

  // The register is free when empty or when its word leaves this cycle.
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (~valid_q | take_i) begin
      valid_d = in_valid_i;
    end
    if (load) begin
      word_d = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = word_q;

endmodule

>>> src/afr_core.sv
// Frame state and validation of the addressed frame receiver.
// Holds the configuration registers and the per-reception state, and processes
// one word per cycle unless a result waits for room. Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           item_valid_i,
  input  afr_pkg::afr_in_t               item_i,
  output logic                           take_o,
  input  logic                           out_free_i,
  output logic                           res_valid_o,
  output afr_pkg::afr_out_t              res_o
);

  localparam int unsigned CW = afr_pkg::CNT_W;

  // Configuration registers.
  logic [15:0] station_q;
  logic [15:0] gap_limit_q;
  logic [10:0] capacity_q;

  // Reception state.
  logic          receiving_q, receiving_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   elapsed_q, elapsed_d;
  logic [15:0]   idle_q, idle_d;
  logic [15:0]   armed_q, armed_d;
  logic [7:0]    lead_q, lead_d;
  logic [15:0]   target_q, target_d;
  logic [7:0]    length_q, length_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    recent0_q, recent0_d;
  logic [7:0]    recent1_q, recent1_d;

  logic              has_res;
  afr_pkg::status_e  status;
  logic [CW-1:0]     res_len;
  logic [CW-1:0]     cap;
  logic [CW-1:0]     cnt_inc;
  logic [15:0]       check_word;
  logic [15:0]       elapsed_inc;
  logic [15:0]       idle_inc;
  logic              in_data;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q   <= afr_pkg::STATION_RESET;
      gap_limit_q <= afr_pkg::GAP_RESET;
      capacity_q  <= afr_pkg::CAPACITY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        afr_pkg::CFG_STATION_ADDRESS: station_q   <= cfg_data_i;
        afr_pkg::CFG_GAP_LIMIT:       gap_limit_q <= cfg_data_i;
        afr_pkg::CFG_RX_CAPACITY:     capacity_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Effective capacity is the smaller of the register and the hardware limit.
  assign cap = (CW'(capacity_q) < CW'(afr_pkg::MAX_CAPACITY)) ?
               CW'(capacity_q) : CW'(afr_pkg::MAX_CAPACITY);
  assign cnt_inc     = count_q + CW'(1);
  assign check_word  = {recent1_q, recent0_q};
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign idle_inc    = (count_q != '0 && idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
  assign in_data     = (count_q >= CW'(afr_pkg::DATA_START)) &&
                       (count_q < CW'(afr_pkg::DATA_START) + CW'(length_q));

  // Next state and result for the word at the head of the input register.
  always_comb begin
    receiving_d = receiving_q;
    count_d     = count_q;
    elapsed_d   = elapsed_q;
    idle_d      = idle_q;
    armed_d     = armed_q;
    lead_d      = lead_q;
    target_d    = target_q;
    length_d    = length_q;
    sum_d       = sum_q;
    recent0_d   = recent0_q;
    recent1_d   = recent1_q;
    has_res     = 1'b0;
    status      = afr_pkg::ST_OK;
    res_len     = count_q;

    case (item_i.action)
      afr_pkg::ACT_START: begin
        count_d     = '0;
        elapsed_d   = '0;
        idle_d      = '0;
        lead_d      = '0;
        target_d    = '0;
        length_d    = '0;
        sum_d       = '0;
        recent0_d   = '0;
        recent1_d   = '0;
        armed_d     = item_i.timeout_ticks;
        receiving_d = 1'b1;
        if (item_i.timeout_ticks == '0) begin
          receiving_d = 1'b0;
          has_res     = 1'b1;
          status      = afr_pkg::ST_TIMEOUT;
          res_len     = '0;
        end
      end
      afr_pkg::ACT_BYTE: begin
        if (receiving_q) begin
          // Fold the byte into the field it belongs to.
          if (count_q == CW'(afr_pkg::POS_LEAD)) begin
            lead_d = item_i.data_byte;
          end else if (count_q == CW'(afr_pkg::POS_ADDR_HI)) begin
            target_d = {item_i.data_byte, target_q[7:0]};
          end else if (count_q == CW'(afr_pkg::POS_ADDR_LO)) begin
            target_d = {target_q[15:8], item_i.data_byte};
          end else if (count_q == CW'(afr_pkg::POS_LENGTH)) begin
            length_d = item_i.data_byte;
          end else if (in_data) begin
            sum_d = sum_q + 16'(item_i.data_byte);
          end
          recent1_d = recent0_q;
          recent0_d = item_i.data_byte;
          count_d   = cnt_inc;
          idle_d    = '0;
          res_len   = cnt_inc;
          if (cnt_inc >= cap) begin
            has_res     = 1'b1;
            receiving_d = 1'b0;
            status      = afr_pkg::ST_OVERFLOW;
          end else if (item_i.data_byte == afr_pkg::EOT_BYTE) begin
            has_res     = 1'b1;
            receiving_d = 1'b0;
            // Checks in priority order.
            if (cnt_inc < CW'(afr_pkg::MIN_FRAME_LEN)) begin
              status = afr_pkg::ST_SHORT;
            end else if (cnt_inc != CW'(length_q) + CW'(afr_pkg::LEN_OVERHEAD)) begin
              status = afr_pkg::ST_LEN_MISM;
            end else if (!(lead_q inside {afr_pkg::SOH_BYTE, afr_pkg::STX_BYTE,
                                          afr_pkg::ACK_BYTE, afr_pkg::NAK_BYTE})) begin
              status = afr_pkg::ST_BAD_START;
            end else if (target_q != station_q) begin
              status = afr_pkg::ST_OTHER_ADDR;
            end else if (sum_q != check_word) begin
              status = afr_pkg::ST_BAD_SUM;
            end else begin
              status = afr_pkg::ST_OK;
            end
          end
        end
      end
      afr_pkg::ACT_TICK: begin
        if (receiving_q) begin
          elapsed_d = elapsed_inc;
          idle_d    = idle_inc;
          // Overall timeout first, then the inter-byte gap.
          if (elapsed_inc >= armed_q ||
              (count_q != '0 && idle_inc > gap_limit_q)) begin
            has_res     = 1'b1;
            receiving_d = 1'b0;
            status      = afr_pkg::ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // A word leaves when it gives no result or the result register has room.
  assign take_o      = item_valid_i & (~has_res | out_free_i);
  assign res_valid_o = take_o & has_res;
  assign res_o.status       = status;
  assign res_o.frame_length = res_len[10:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      count_q     <= '0;
      elapsed_q   <= '0;
      idle_q      <= '0;
      armed_q     <= '0;
      lead_q      <= '0;
      target_q    <= '0;
      length_q    <= '0;
      sum_q       <= '0;
      recent0_q   <= '0;
      recent1_q   <= '0;
    end else if (take_o) begin
      receiving_q <= receiving_d;
      count_q     <= count_d;
      elapsed_q   <= elapsed_d;
      idle_q      <= idle_d;
      armed_q     <= armed_d;
      lead_q      <= lead_d;
      target_q    <= target_d;
      length_q    <= length_d;
      sum_q       <= sum_d;
      recent0_q   <= recent0_d;
      recent1_q   <= recent1_d;
    end
  end

endmodule

>>> src/afr_out_stage.sv
// Result register of the addressed frame receiver.
// Holds one result word until the receiving side takes it.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  afr_pkg::afr_out_t res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output afr_pkg::afr_out_t out_data_o
);

  logic              valid_q, valid_d;
  afr_pkg::afr_out_t word_q, word_d;

  // Room exists when empty or when the held word is taken this cycle.
  assign out_free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (out_free_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        word_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = word_q;

endmodule

>>> src/addressed_frame_receiver.sv
// Top level of the addressed frame receiver.
// Instantiates afr_in_stage, afr_core and afr_out_stage; uses afr_pkg.
`timescale 1ns / 1ps

// Receives bus frames one word at a time: a start word arms a reception with
// an overall timeout, byte words are counted and folded into the frame state,
// and tick words age the overall and inter-byte timers. A reception ends at
// the first EOT byte, when the byte count reaches the capacity, or on a
// timeout, and then gives one result word with a status and the frame length.
// Each word is captured in an input register, processed by the state update,
// and any result is placed in an output register, so a new word is accepted
// every cycle while results drain. The word that causes a result is held in the
// input register first, and the result then in the output register. A word
// that gives a result waits in the input register while the output register
// holds a stalled result, and the input stalls meanwhile.
// Configuration writes take effect on the next cycle and must happen while no
// reception is in flight through the pipeline.

module addressed_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [afr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  afr_pkg::afr_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output afr_pkg::afr_out_t              out_data_o
);

  logic              item_valid;
  afr_pkg::afr_in_t  item;
  logic              take;
  logic              out_free;
  logic              res_valid;
  afr_pkg::afr_out_t res;

  // Input register.
  afr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  // Frame state, timers and validation.
  afr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register.
  afr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_addressed_frame_receiver.sv
`timescale 1ns / 1ps
// Self-checking bench for addressed_frame_receiver: directed and random start, byte and
// tick words, with every result word checked against a frame-state predictor.
// Depends on afr_pkg and addressed_frame_receiver from src.

import afr_pkg::*;

// Predicts the result word of each reception and checks result words in order.
class frame_scoreboard;
  logic [15:0] station_addr;
  logic [15:0] gap_limit;
  logic [10:0] capacity;

  bit          active;
  int unsigned nbytes;
  int unsigned elapsed;
  int unsigned idle;
  int unsigned armed;
  logic [7:0]  lead;
  logic [7:0]  len_byte;
  logic [7:0]  last_byte;
  logic [7:0]  prev_byte;
  logic [15:0] target;
  logic [15:0] data_sum;

  afr_out_t    expected_q[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned status_seen[8];

  function new();
    station_addr = STATION_RESET;
    gap_limit    = GAP_RESET;
    capacity     = CAPACITY_RESET;
    active       = 1'b0;
    armed        = 0;
    mismatches   = 0;
    checked      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    nbytes    = 0;
    elapsed   = 0;
    idle      = 0;
    lead      = '0;
    target    = '0;
    len_byte  = '0;
    data_sum  = '0;
    last_byte = '0;
    prev_byte = '0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [15:0] val);
    case (idx)
      CFG_STATION_ADDRESS: station_addr = val;
      CFG_GAP_LIMIT:       gap_limit = val;
      CFG_RX_CAPACITY:     capacity = val[10:0];
      default: ;
    endcase
  endfunction

  // Ends the reception and queues its result word.
  function void close(status_e st, int unsigned n);
    afr_out_t r;
    r.status       = st;
    r.frame_length = n[10:0];
    expected_q.push_back(r);
    active = 1'b0;
  endfunction

  // Frame checks at EOT, in priority order.
  function status_e frame_status(int unsigned n, logic [15:0] check);
    if (n < MIN_FRAME_LEN) return ST_SHORT;
    if (n != len_byte + LEN_OVERHEAD) return ST_LEN_MISM;
    if (!(lead == SOH_BYTE || lead == STX_BYTE || lead == ACK_BYTE || lead == NAK_BYTE))
      return ST_BAD_START;
    if (target != station_addr) return ST_OTHER_ADDR;
    if (data_sum != check) return ST_BAD_SUM;
    return ST_OK;
  endfunction

  // Applies one accepted word; returns 1 when the block acts on it.
  function bit note_word(afr_in_t w);
    int unsigned limit;
    int unsigned pos;
    logic [15:0] check;
    if (w.action == ACT_START) begin
      restart_frame();
      armed  = w.timeout_ticks;
      active = 1'b1;
      if (armed == 0) close(ST_TIMEOUT, 0);
      return 1'b1;
    end
    if (!active) return 1'b0;
    if (w.action == ACT_BYTE) begin
      pos   = nbytes;
      limit = (capacity < MAX_CAPACITY) ? capacity : MAX_CAPACITY;
      check = {prev_byte, last_byte};
      if (pos == POS_LEAD) lead = w.data_byte;
      else if (pos == POS_ADDR_HI) target[15:8] = w.data_byte;
      else if (pos == POS_ADDR_LO) target[7:0] = w.data_byte;
      else if (pos == POS_LENGTH) len_byte = w.data_byte;
      else if (pos >= DATA_START && pos < DATA_START + len_byte)
        data_sum = data_sum + w.data_byte;
      prev_byte = last_byte;
      last_byte = w.data_byte;
      if (nbytes < 65535) nbytes++;
      idle = 0;
      if (nbytes >= limit) close(ST_OVERFLOW, nbytes);
      else if (w.data_byte == EOT_BYTE) close(frame_status(nbytes, check), nbytes);
      return 1'b1;
    end
    if (w.action == ACT_TICK) begin
      if (elapsed < 65535) elapsed++;
      if (nbytes > 0 && idle < 65535) idle++;
      // The overall timeout takes priority over the inter-byte gap.
      if (elapsed >= armed) close(ST_TIMEOUT, nbytes);
      else if (nbytes > 0 && idle > gap_limit) close(ST_TIMEOUT, nbytes);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void check_result(afr_out_t got);
    afr_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected: status %0d length %0d",
               $time, got.status, got.frame_length);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    status_seen[want.status]++;
    if (got.status !== want.status) begin
      mismatches++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
    end
    if (got.frame_length !== want.frame_length) begin
      mismatches++;
      $display("%0t: frame_length expected %0d actual %0d",
               $time, want.frame_length, got.frame_length);
    end
  endfunction
endclass

module tb_addressed_frame_receiver;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  afr_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  afr_out_t              out_data_o;

  frame_scoreboard sb;
  bit              idling = 1'b1;
  int unsigned     words_done = 0;
  int unsigned     settings_used = 1;
  int unsigned     stall_hold = 0;
  int unsigned     quiet_cycles = 0;

  addressed_frame_receiver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check accepted words and, while idling is set, stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (!idling) begin
      stall_hold = 0;
      out_stall_i <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_hold = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: too many cycles without any word moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("tb_addressed_frame_receiver: done, errors");
        $finish;
      end
    end
  end

  function automatic afr_in_t make_word(logic [1:0] act, logic [7:0] b, logic [15:0] t);
    afr_in_t w;
    w.action        = act;
    w.data_byte     = b;
    w.timeout_ticks = t;
    return w;
  endfunction

  // Random byte that cannot end the frame early.
  function automatic logic [7:0] clean_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == EOT_BYTE) v = v + 8'd1;
    return v;
  endfunction

  // Offers one word, with an optional idle burst first, and waits for acceptance.
  task automatic send_word(afr_in_t w);
    if (idling && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.note_word(w)) words_done++;
  endtask

  task automatic put_start(logic [15:0] tmo);
    send_word(make_word(ACT_START, 8'($urandom), tmo));
  endtask

  task automatic put_byte(logic [7:0] b);
    send_word(make_word(ACT_BYTE, b, 16'($urandom)));
  endtask

  task automatic put_ticks(int unsigned n);
    repeat (n) send_word(make_word(ACT_TICK, 8'($urandom), 16'($urandom)));
  endtask

  // Holds the sender until every expected result has come, then lets the pipe settle.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Forces the block idle with a zero-timeout start, drains, then writes all registers.
  task automatic apply_setting(logic [15:0] station, logic [15:0] gap, logic [10:0] cap);
    put_start(16'd0);
    wait_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_STATION_ADDRESS;
    cfg_data_i <= station;
    @(posedge clk_i);
    sb.set_reg(CFG_STATION_ADDRESS, station);
    cfg_idx_i  <= CFG_GAP_LIMIT;
    cfg_data_i <= gap;
    @(posedge clk_i);
    sb.set_reg(CFG_GAP_LIMIT, gap);
    cfg_idx_i  <= CFG_RX_CAPACITY;
    cfg_data_i <= {5'd0, cap};
    @(posedge clk_i);
    sb.set_reg(CFG_RX_CAPACITY, {5'd0, cap});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // One reception of a frame aimed at this station, mostly well formed, sometimes flawed.
  task automatic send_frame();
    logic [7:0]  line[$];
    logic [15:0] sum;
    logic [15:0] tmo;
    logic [7:0]  v;
    int unsigned cap, lmax, len, flaw, cut, breach, spare, i;
    cap  = (sb.capacity < MAX_CAPACITY) ? sb.capacity : MAX_CAPACITY;
    lmax = (cap > MIN_FRAME_LEN) ? cap - MIN_FRAME_LEN : 0;
    if (lmax > 255) lmax = 255;
    flaw = $urandom_range(0, 15);
    if (flaw == 14) len = $urandom_range(0, 255);
    else if (lmax == 0) len = 0;
    else if ($urandom_range(0, 7) == 0) len = $urandom_range(0, lmax);
    else len = $urandom_range(1, (lmax < 12) ? lmax : 12);

    // Lead, address, two free bytes, length, data, checksum, EOT.
    case ($urandom_range(0, 3))
      0: line.push_back(SOH_BYTE);
      1: line.push_back(STX_BYTE);
      2: line.push_back(ACK_BYTE);
      default: line.push_back(NAK_BYTE);
    endcase
    line.push_back(sb.station_addr[15:8]);
    line.push_back(sb.station_addr[7:0]);
    line.push_back(clean_byte());
    line.push_back(clean_byte());
    line.push_back(len[7:0]);
    sum = '0;
    for (i = 0; i < len; i++) begin
      v   = clean_byte();
      sum = sum + v;
      line.push_back(v);
    end
    line.push_back(sum[15:8]);
    line.push_back(sum[7:0]);
    line.push_back(EOT_BYTE);

    // Damage the frame in one way, if at all.
    case (flaw)
      9:  line[0] = clean_byte();
      10: line[2] = line[2] ^ 8'($urandom_range(1, 255));
      11: line[5] = line[5] + 8'($urandom_range(1, 255));
      12: line[line.size()-2] = line[line.size()-2] ^ 8'($urandom_range(1, 255));
      13: begin
        cut = $urandom_range(0, line.size() - 2);
        line[cut] = EOT_BYTE;
        while (line.size() > cut + 1) void'(line.pop_back());
      end
      default: ;
    endcase

    tmo    = 16'($urandom_range(2000, 65535));
    spare  = (sb.gap_limit < 3) ? sb.gap_limit : 3;
    breach = 0;
    if (flaw == 15) begin
      if (sb.gap_limit <= 64) breach = $urandom_range(1, line.size() - 1);
      else tmo = 16'($urandom_range(1, 40));
    end
    put_start(tmo);
    for (i = 0; i < line.size(); i++) begin
      if (breach != 0 && i == breach) put_ticks(sb.gap_limit + 1);
      else if ($urandom_range(0, 3) == 0 || (flaw == 15 && breach == 0))
        put_ticks($urandom_range(0, spare));
      put_byte(line[i]);
    end
  endtask

  task automatic send_exchange();
    case ($urandom_range(0, 9))
      // Noise: any action, any field values.
      0: repeat ($urandom_range(1, 10))
           send_word(make_word(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom)));
      // Reception left unfinished; the next start drops it.
      1: begin
        put_start(16'($urandom_range(100, 65535)));
        repeat ($urandom_range(1, 8)) put_byte(clean_byte());
      end
      default: send_frame();
    endcase
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned target;
    target = words_done + budget;
    while (words_done < target) send_exchange();
  endtask

  function automatic logic [15:0] pick_station();
    logic [15:0] v;
    v = 16'($urandom);
    if (v[15:8] == EOT_BYTE) v[15:8] = 8'h05;
    if (v[7:0] == EOT_BYTE) v[7:0] = 8'h05;
    return v;
  endfunction

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings.
    put_start(16'd0);
    put_byte(8'hFF);
    put_ticks(1);
    send_word(make_word(ACT_UNUSED, 8'hFF, 16'hFFFF));
    put_start(16'hFFFF);
    put_byte(SOH_BYTE);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(EOT_BYTE);
    put_start(16'd2);
    put_ticks(2);
    put_start(16'hFFFF);
    put_byte(NAK_BYTE);
    put_start(16'hFFFF);
    put_byte(EOT_BYTE);

    // Random part over several register settings, extremes included.
    apply_setting(16'h5A3C, 16'd1, 11'd10);
    run_random(150);
    apply_setting(16'hFFFF, 16'hFFFF, 11'd1024);
    put_start(16'hFFFF);
    repeat (MAX_CAPACITY + 2) put_byte(clean_byte());
    run_random(200);
    apply_setting(pick_station(), 16'($urandom_range(2, 20)), 11'($urandom_range(10, 300)));
    run_random(350);
    idling = 1'b0;
    apply_setting(16'h0000, 16'd10, 11'($urandom_range(40, 200)));
    run_random(220);

    wait_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d words acted on over %0d register settings; %0d results checked.",
             words_done, settings_used, sb.checked);
    $display("By status: ok %0d short %0d len %0d start %0d addr %0d sum %0d ovf %0d tmo %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_SHORT], sb.status_seen[ST_LEN_MISM],
             sb.status_seen[ST_BAD_START], sb.status_seen[ST_OTHER_ADDR],
             sb.status_seen[ST_BAD_SUM], sb.status_seen[ST_OVERFLOW],
             sb.status_seen[ST_TIMEOUT]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_addressed_frame_receiver: done, clean");
    end else begin
      $display("tb_addressed_frame_receiver: done, errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/afr_pkg.sv
src/afr_in_stage.sv
src/afr_core.sv
src/afr_out_stage.sv
src/addressed_frame_receiver.sv
bench/tb_addressed_frame_receiver.sv
